[rtl/core/e2g_pkg.sv]
// ----------------------------------------------------------------------------
// e2g_pkg
// Shared constants, register indexes and helper functions for the ECEF to
// geodetic converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2g_pkg;

  // field and register widths
  localparam int unsigned POS_W     = 48;
  localparam int unsigned ANG_W     = 32;
  localparam int unsigned RADIUS_W  = 40;
  localparam int unsigned FLAT_W    = 32;
  localparam int unsigned TOL_W     = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 40;

  // shared unit widths
  localparam int unsigned MUL_W   = 64;
  localparam int unsigned SQRT_RW = 128;
  localparam int unsigned SQRT_W  = 64;
  localparam int unsigned DIV_NW  = 96;
  localparam int unsigned DIV_DW  = 64;

  localparam int unsigned CORDIC_STEPS = 30;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 40'd6378137000;
  localparam logic [FLAT_W-1:0]   FLAT_RST   = 32'd14400281;
  localparam logic [TOL_W-1:0]    TOL_RST    = 20'd1;

  localparam int MAX_ITER_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_FLAT   = 2'd1,
    REG_TOL    = 2'd2
  } cfg_reg_e;

  // magnitude of a two's complement word
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] res;
    res = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    return res;
  endfunction

  // arctangent of 2^-i, LSB pi/2^31 rad
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] res;
    case (i)
      5'd0:    res = 32'd536870912;
      5'd1:    res = 32'd316933406;
      5'd2:    res = 32'd167458907;
      5'd3:    res = 32'd85004756;
      5'd4:    res = 32'd42667331;
      5'd5:    res = 32'd21354465;
      5'd6:    res = 32'd10679838;
      5'd7:    res = 32'd5340245;
      5'd8:    res = 32'd2670163;
      5'd9:    res = 32'd1335087;
      5'd10:   res = 32'd667544;
      5'd11:   res = 32'd333772;
      5'd12:   res = 32'd166886;
      5'd13:   res = 32'd83443;
      5'd14:   res = 32'd41721;
      5'd15:   res = 32'd20860;
      5'd16:   res = 32'd10430;
      5'd17:   res = 32'd5215;
      5'd18:   res = 32'd2607;
      5'd19:   res = 32'd1303;
      5'd20:   res = 32'd651;
      5'd21:   res = 32'd325;
      5'd22:   res = 32'd162;
      5'd23:   res = 32'd81;
      5'd24:   res = 32'd40;
      5'd25:   res = 32'd20;
      5'd26:   res = 32'd10;
      5'd27:   res = 32'd5;
      5'd28:   res = 32'd2;
      5'd29:   res = 32'd1;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/e2g_mul.sv]
// ----------------------------------------------------------------------------
// e2g_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [e2g_pkg::MUL_W-1:0]     a_i,
  input  wire logic [e2g_pkg::MUL_W-1:0]     b_i,
  output logic                               done_o,
  output logic [2*e2g_pkg::MUL_W-1:0]        p_o
);

  localparam int unsigned HW = e2g_pkg::MUL_W / 2;

  logic [e2g_pkg::MUL_W-1:0]   a_q, a_d, b_q, b_d;
  logic [2*e2g_pkg::MUL_W-1:0] acc_q, acc_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;

  logic [HW-1:0]               ah, bh;
  logic [2*HW-1:0]             pp;
  logic [1:0]                  shamt;

  always_comb begin
    ah    = cnt_q[0] ? a_q[2*HW-1:HW] : a_q[HW-1:0];
    bh    = cnt_q[1] ? b_q[2*HW-1:HW] : b_q[HW-1:0];
    pp    = ah * bh;
    // partial product weight in units of half words
    shamt = {cnt_q[0] & cnt_q[1], cnt_q[0] ^ cnt_q[1]};

    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + ({{(2*e2g_pkg::MUL_W-2*HW){1'b0}}, pp} << (32'(shamt) * HW));
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

[rtl/core/e2g_sqrt.sv]
// ----------------------------------------------------------------------------
// e2g_sqrt
// Floor square root of a 128-bit word, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [e2g_pkg::SQRT_RW-1:0]   rad_i,
  output logic                               done_o,
  output logic [e2g_pkg::SQRT_W-1:0]         root_o
);

  localparam int unsigned CW = $clog2(e2g_pkg::SQRT_W);
  localparam int unsigned RW = e2g_pkg::SQRT_W + 2;

  logic [e2g_pkg::SQRT_RW-1:0] rad_q, rad_d;
  logic [RW-1:0]               rem_q, rem_d;
  logic [e2g_pkg::SQRT_W-1:0]  root_q, root_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;

  logic [RW+1:0]               rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q, rad_q[e2g_pkg::SQRT_RW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};

    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[e2g_pkg::SQRT_RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = RW'(rem_sh - trial);
        root_d = {root_q[e2g_pkg::SQRT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[RW-1:0];
        root_d = {root_q[e2g_pkg::SQRT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(e2g_pkg::SQRT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/core/e2g_div.sv]
// ----------------------------------------------------------------------------
// e2g_div
// Restoring divider, 96-bit dividend by 64-bit divisor, one quotient bit per
// cycle; quotient saturates to 64 bits, divide by zero gives all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          go_i,
  input  wire logic [e2g_pkg::DIV_NW-1:0]    num_i,
  input  wire logic [e2g_pkg::DIV_DW-1:0]    den_i,
  output logic                               done_o,
  output logic [e2g_pkg::DIV_DW-1:0]         quo_o
);

  localparam int unsigned NW = e2g_pkg::DIV_NW;
  localparam int unsigned DW = e2g_pkg::DIV_DW;
  localparam int unsigned CW = $clog2(NW);

  logic [NW-1:0] num_q, num_d;   // dividend shifts out, quotient shifts in
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  logic [DW:0]   rem_sh, den_ext;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[NW-1]};
    den_ext = {1'b0, den_q};
    ge      = (rem_sh >= den_ext);

    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DW'(rem_sh - den_ext) : rem_sh[DW-1:0];
      num_d = {num_q[NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = ((den_q == '0) || (num_q[NW-1:DW] != '0)) ? '1 : num_q[DW-1:0];

endmodule

`default_nettype wire

[rtl/core/e2g_cordic.sv]
// ----------------------------------------------------------------------------
// e2g_cordic
// Vectoring CORDIC atan2(y, x): quadrant fold, normalization, 30 rotations.
// ----------------------------------------------------------------------------
`default_nettype none

module e2g_cordic (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        go_i,
  input  wire logic signed [63:0]          y_i,
  input  wire logic signed [63:0]          x_i,
  output logic                             done_o,
  output logic [e2g_pkg::ANG_W-1:0]        ang_o
);

  typedef enum logic [1:0] {C_IDLE, C_PREP, C_NORM, C_ITER} cstate_e;

  localparam logic [63:0] M_HI   = 64'h0800_0000_0000_0000;  // 2^59
  localparam logic [63:0] M_LO   = 64'h0400_0000_0000_0000;  // 2^58
  localparam logic [63:0] M_FAST = 64'h0004_0000_0000_0000;  // 2^50
  localparam logic [31:0] QTR    = 32'h4000_0000;

  cstate_e               state_q, state_d;
  logic                  done_q, done_d;
  logic [31:0]           ang_q, ang_d;
  logic signed [63:0]    x_q, x_d, y_q, y_d;
  logic [4:0]            i_q, i_d;

  logic [63:0]           mx, my, m;
  logic signed [63:0]    xs, ys;

  always_comb begin
    mx = e2g_pkg::mag64(x_q);
    my = e2g_pkg::mag64(y_q);
    m  = (mx > my) ? mx : my;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;

    state_d = state_q;
    done_d  = 1'b0;
    ang_d   = ang_q;
    x_d     = x_q;
    y_d     = y_q;
    i_d     = i_q;
    unique case (state_q)
      C_IDLE: begin
        if (go_i) begin
          x_d     = x_i;
          y_d     = y_i;
          state_d = C_PREP;
        end
      end
      C_PREP: begin
        ang_d = '0;
        if (x_q == '0 && y_q == '0) begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end else begin
          // fold the left half plane onto the right
          if (x_q < 0) begin
            if (y_q >= 0) begin
              x_d   = y_q;
              y_d   = -x_q;
              ang_d = QTR;
            end else begin
              x_d   = -y_q;
              y_d   = x_q;
              ang_d = -QTR;
            end
          end
          state_d = C_NORM;
        end
      end
      C_NORM: begin
        i_d = '0;
        if (m >= M_HI) begin
          x_d = x_q >>> 1;
          y_d = y_q >>> 1;
        end else if (m < M_FAST) begin
          x_d = x_q <<< 8;
          y_d = y_q <<< 8;
        end else if (m < M_LO) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          state_d = C_ITER;
        end
      end
      C_ITER: begin
        if (y_q >= 0) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          ang_d = ang_q + e2g_pkg::atan_entry(i_q);
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          ang_d = ang_q - e2g_pkg::atan_entry(i_q);
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'(e2g_pkg::CORDIC_STEPS - 1)) begin
          done_d  = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ang_q   <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    i_q <= i_d;
  end

  assign done_o = done_q;
  assign ang_o  = ang_q;

endmodule

`default_nettype wire

[rtl/core/ecef_to_geodetic_converter.sv]
// ----------------------------------------------------------------------------
// ecef_to_geodetic_converter
// Cartesian (mm) to geodetic altitude, latitude and longitude.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with pos_x_i, pos_y_i, pos_z_i. A
//   transaction is taken when valid is high and stall is low. in_stall_o is
//   high from the cycle after a transaction until the result has been moved
//   to the output register, so one item is in work at a time.
// Output channel: out_valid_o / out_stall_i with altitude_o, latitude_o,
//   longitude_o, not_converged_o. The result sits in an output register; a
//   new item is taken while a finished result still waits there. If the
//   receiver stalls, the next result waits in the final state until the
//   output register frees.
// Config: cfg_we_i / cfg_index_i / cfg_data_i, write while idle only.
// Units: one 32x32 multiplier that builds each 64x64 product, a bit-serial
//   square root and divider and a CORDIC unit are shared under one
//   sequencer. Each refinement takes two roots, two divisions (one when r is
//   zero) and five products; setup and the final pass come on top. An item
//   takes k refinements, 1 <= k <= MAX_ITERATIONS.
// Reset: registers return to their default ellipsoid, nothing is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module ecef_to_geodetic_converter #(
  parameter int MAX_ITERATIONS = e2g_pkg::MAX_ITER_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [e2g_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [e2g_pkg::CFG_W-1:0]          cfg_data_i,
  // input transactions
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [e2g_pkg::POS_W-1:0]   pos_x_i,
  input  wire logic signed [e2g_pkg::POS_W-1:0]   pos_y_i,
  input  wire logic signed [e2g_pkg::POS_W-1:0]   pos_z_i,
  // result transactions
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [e2g_pkg::POS_W-1:0]        altitude_o,
  output logic signed [e2g_pkg::ANG_W-1:0]        latitude_o,
  output logic signed [e2g_pkg::ANG_W-1:0]        longitude_o,
  output logic                                    not_converged_o
);

  localparam int unsigned KW = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned PW = e2g_pkg::POS_W;
  localparam int unsigned EW = 16;  // sign extension 48 -> 64

  localparam logic [31:0]        ONE_Q31 = 32'h8000_0000;
  localparam logic signed [64:0] ALT_HI  = 65'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] ALT_LO  = -65'sh0_7FFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_FF, S_RX, S_RY, S_OFF0, S_DZ, S_R2, S_R, S_S, S_S2, S_Q, S_SD,
    S_N, S_T, S_OFF, S_CHK, S_RHO, S_LAT, S_LON, S_DONE
  } state_e;

  // control
  state_e                       state_q, state_d;
  logic                         fin_q, fin_d;     // final pass after the loop
  logic                         conv_q, conv_d;
  logic [KW-1:0]                kcnt_q, kcnt_d;
  logic                         out_valid_q, out_valid_d;

  // configuration registers
  logic [e2g_pkg::RADIUS_W-1:0] radius_q, radius_d;
  logic [e2g_pkg::FLAT_W-1:0]   flat_q, flat_d;
  logic [e2g_pkg::TOL_W-1:0]    tol_q, tol_d;

  // shared unit requests
  logic                         mul_go_q, mul_go_d;
  logic [63:0]                  mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic                         sqrt_go_q, sqrt_go_d;
  logic [127:0]                 sqrt_rad_q, sqrt_rad_d;
  logic                         div_go_q, div_go_d;
  logic [95:0]                  div_num_q, div_num_d;
  logic [63:0]                  div_den_q, div_den_d;
  logic                         cor_go_q, cor_go_d;
  logic signed [63:0]           cor_y_q, cor_y_d, cor_x_q, cor_x_d;

  // shared unit results
  logic                         mul_done, sqrt_done, div_done, cor_done;
  logic [127:0]                 mul_p;
  logic [63:0]                  sqrt_root, div_quo;
  logic [31:0]                  cor_ang;

  // item datapath
  logic signed [PW-1:0]         x_q, x_d, y_q, y_d, z_q, z_d;
  logic [32:0]                  e2_q, e2_d;
  logic [95:0]                  rho2_q, rho2_d;
  logic signed [63:0]           off_q, off_d, old_q, old_d, dz_q, dz_d;
  logic [63:0]                  adz_q, adz_d, n_q, n_d;
  logic [31:0]                  s_q, s_d;
  logic [PW-1:0]                alt_q, alt_d;
  logic [31:0]                  lat_q, lat_d, lon_q, lon_d;

  // output registers
  logic [PW-1:0]                out_alt_q, out_alt_d;
  logic [31:0]                  out_lat_q, out_lat_d, out_lon_q, out_lon_d;
  logic                         out_nc_q, out_nc_d;

  // combinational helpers
  logic signed [63:0]           x64, y64, z64, dz_new;
  logic [63:0]                  offm;
  logic [33:0]                  e2_full;
  logic [31:0]                  qv, qc, dv;
  logic signed [64:0]           alt_w;

  e2g_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  e2g_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go_q),
    .rad_i  (sqrt_rad_q),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  e2g_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  e2g_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cor_go_q),
    .y_i    (cor_y_q),
    .x_i    (cor_x_q),
    .done_o (cor_done),
    .ang_o  (cor_ang)
  );

  always_comb begin
    x64     = {{EW{x_q[PW-1]}}, x_q};
    y64     = {{EW{y_q[PW-1]}}, y_q};
    z64     = {{EW{z_q[PW-1]}}, z_q};
    dz_new  = z64 + off_q;
    e2_full = {1'b0, flat_q, 1'b0} - {2'b00, mul_p[63:32]};
    qv      = mul_p[63:32];
    qc      = (qv > ONE_Q31) ? ONE_Q31 : qv;
    dv      = ONE_Q31 - qc;
    alt_w   = $signed({1'b0, sqrt_root}) - $signed({1'b0, n_q});
    offm    = '0;

    state_d     = state_q;
    fin_d       = fin_q;
    conv_d      = conv_q;
    kcnt_d      = kcnt_q;
    out_valid_d = out_valid_q & out_stall_i;

    radius_d = radius_q;
    flat_d   = flat_q;
    tol_d    = tol_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        e2g_pkg::REG_RADIUS: radius_d = cfg_data_i;
        e2g_pkg::REG_FLAT:   flat_d   = cfg_data_i[e2g_pkg::FLAT_W-1:0];
        e2g_pkg::REG_TOL:    tol_d    = cfg_data_i[e2g_pkg::TOL_W-1:0];
        default:             ;
      endcase
    end

    mul_go_d   = 1'b0;
    mul_a_d    = mul_a_q;
    mul_b_d    = mul_b_q;
    sqrt_go_d  = 1'b0;
    sqrt_rad_d = sqrt_rad_q;
    div_go_d   = 1'b0;
    div_num_d  = div_num_q;
    div_den_d  = div_den_q;
    cor_go_d   = 1'b0;
    cor_y_d    = cor_y_q;
    cor_x_d    = cor_x_q;

    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    e2_d   = e2_q;
    rho2_d = rho2_q;
    off_d  = off_q;
    old_d  = old_q;
    dz_d   = dz_q;
    adz_d  = adz_q;
    n_d    = n_q;
    s_d    = s_q;
    alt_d  = alt_q;
    lat_d  = lat_q;
    lon_d  = lon_q;

    out_alt_d = out_alt_q;
    out_lat_d = out_lat_q;
    out_lon_d = out_lon_q;
    out_nc_d  = out_nc_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d      = pos_x_i;
          y_d      = pos_y_i;
          z_d      = pos_z_i;
          fin_d    = 1'b0;
          kcnt_d   = '0;
          mul_go_d = 1'b1;
          mul_a_d  = {32'd0, flat_q};
          mul_b_d  = {32'd0, flat_q};
          state_d  = S_FF;
        end
      end
      S_FF: begin
        // e2 = 2f - f^2, Q0.32
        if (mul_done) begin
          e2_d     = e2_full[32:0];
          mul_go_d = 1'b1;
          mul_a_d  = e2g_pkg::mag64(x64);
          mul_b_d  = e2g_pkg::mag64(x64);
          state_d  = S_RX;
        end
      end
      S_RX: begin
        if (mul_done) begin
          rho2_d   = mul_p[95:0];
          mul_go_d = 1'b1;
          mul_a_d  = e2g_pkg::mag64(y64);
          mul_b_d  = e2g_pkg::mag64(y64);
          state_d  = S_RY;
        end
      end
      S_RY: begin
        if (mul_done) begin
          rho2_d   = rho2_q + mul_p[95:0];
          mul_go_d = 1'b1;
          mul_a_d  = {31'd0, e2_q};
          mul_b_d  = e2g_pkg::mag64(z64);
          state_d  = S_OFF0;
        end
      end
      S_OFF0: begin
        if (mul_done) begin
          offm    = mul_p[95:32];
          off_d   = z_q[PW-1] ? -$signed(offm) : $signed(offm);
          state_d = S_DZ;
        end
      end
      S_DZ: begin
        // shared by every refinement and the final pass
        dz_d     = dz_new;
        adz_d    = e2g_pkg::mag64(dz_new);
        old_d    = off_q;
        mul_go_d = 1'b1;
        mul_a_d  = e2g_pkg::mag64(dz_new);
        mul_b_d  = e2g_pkg::mag64(dz_new);
        state_d  = S_R2;
      end
      S_R2: begin
        if (mul_done) begin
          sqrt_go_d  = 1'b1;
          sqrt_rad_d = {32'd0, rho2_q} + mul_p;
          state_d    = S_R;
        end
      end
      S_R: begin
        if (sqrt_done) begin
          if (fin_q) begin
            if (alt_w > ALT_HI) begin
              alt_d = ALT_HI[PW-1:0];
            end else if (alt_w < ALT_LO) begin
              alt_d = ALT_LO[PW-1:0];
            end else begin
              alt_d = alt_w[PW-1:0];
            end
            sqrt_go_d  = 1'b1;
            sqrt_rad_d = {32'd0, rho2_q};
            state_d    = S_RHO;
          end else if (sqrt_root == '0) begin
            // r of zero: sine term is zero
            s_d      = '0;
            mul_go_d = 1'b1;
            mul_a_d  = '0;
            mul_b_d  = '0;
            state_d  = S_S2;
          end else begin
            div_go_d  = 1'b1;
            div_num_d = {1'b0, adz_q, 31'd0};
            div_den_d = sqrt_root;
            state_d   = S_S;
          end
        end
      end
      S_S: begin
        if (div_done) begin
          s_d      = (div_quo > {32'd0, ONE_Q31}) ? ONE_Q31 : div_quo[31:0];
          mul_go_d = 1'b1;
          mul_a_d  = (div_quo > {32'd0, ONE_Q31}) ? {32'd0, ONE_Q31} : {32'd0, div_quo[31:0]};
          mul_b_d  = (div_quo > {32'd0, ONE_Q31}) ? {32'd0, ONE_Q31} : {32'd0, div_quo[31:0]};
          state_d  = S_S2;
        end
      end
      S_S2: begin
        if (mul_done) begin
          mul_go_d = 1'b1;
          mul_a_d  = {31'd0, e2_q};
          mul_b_d  = {32'd0, mul_p[62:31]};
          state_d  = S_Q;
        end
      end
      S_Q: begin
        // d = 1 - e2*s^2, kept at one LSB when it vanishes
        if (mul_done) begin
          sqrt_go_d  = 1'b1;
          sqrt_rad_d = {65'd0, (dv == '0) ? 32'd1 : dv, 31'd0};
          state_d    = S_SD;
        end
      end
      S_SD: begin
        if (sqrt_done) begin
          div_go_d  = 1'b1;
          div_num_d = {25'd0, radius_q, 31'd0};
          div_den_d = {32'd0, sqrt_root[31:0]};
          state_d   = S_N;
        end
      end
      S_N: begin
        if (div_done) begin
          n_d      = div_quo;
          mul_go_d = 1'b1;
          mul_a_d  = div_quo;
          mul_b_d  = {31'd0, e2_q};
          state_d  = S_T;
        end
      end
      S_T: begin
        if (mul_done) begin
          mul_go_d = 1'b1;
          mul_a_d  = mul_p[95:32];
          mul_b_d  = {32'd0, s_q};
          state_d  = S_OFF;
        end
      end
      S_OFF: begin
        if (mul_done) begin
          offm    = mul_p[94:31];
          off_d   = dz_q[63] ? -$signed(offm) : $signed(offm);
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        conv_d  = (e2g_pkg::mag64(old_q - off_q) <= {44'd0, tol_q});
        kcnt_d  = kcnt_q + 1'b1;
        if ((e2g_pkg::mag64(old_q - off_q) <= {44'd0, tol_q}) ||
            (kcnt_q == KW'(MAX_ITERATIONS - 1))) begin
          fin_d = 1'b1;
        end
        state_d = S_DZ;
      end
      S_RHO: begin
        if (sqrt_done) begin
          cor_go_d = 1'b1;
          cor_y_d  = dz_q;
          cor_x_d  = $signed(sqrt_root);
          state_d  = S_LAT;
        end
      end
      S_LAT: begin
        if (cor_done) begin
          lat_d    = cor_ang;
          cor_go_d = 1'b1;
          cor_y_d  = y64;
          cor_x_d  = x64;
          state_d  = S_LON;
        end
      end
      S_LON: begin
        if (cor_done) begin
          lon_d   = cor_ang;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_alt_d   = alt_q;
          out_lat_d   = lat_q;
          out_lon_d   = lon_q;
          out_nc_d    = ~conv_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      conv_q      <= 1'b0;
      kcnt_q      <= '0;
      out_valid_q <= 1'b0;
      radius_q    <= e2g_pkg::RADIUS_RST;
      flat_q      <= e2g_pkg::FLAT_RST;
      tol_q       <= e2g_pkg::TOL_RST;
      mul_go_q    <= 1'b0;
      sqrt_go_q   <= 1'b0;
      div_go_q    <= 1'b0;
      cor_go_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      conv_q      <= conv_d;
      kcnt_q      <= kcnt_d;
      out_valid_q <= out_valid_d;
      radius_q    <= radius_d;
      flat_q      <= flat_d;
      tol_q       <= tol_d;
      mul_go_q    <= mul_go_d;
      sqrt_go_q   <= sqrt_go_d;
      div_go_q    <= div_go_d;
      cor_go_q    <= cor_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    sqrt_rad_q <= sqrt_rad_d;
    div_num_q  <= div_num_d;
    div_den_q  <= div_den_d;
    cor_y_q    <= cor_y_d;
    cor_x_q    <= cor_x_d;
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    e2_q       <= e2_d;
    rho2_q     <= rho2_d;
    off_q      <= off_d;
    old_q      <= old_d;
    dz_q       <= dz_d;
    adz_q      <= adz_d;
    n_q        <= n_d;
    s_q        <= s_d;
    alt_q      <= alt_d;
    lat_q      <= lat_d;
    lon_q      <= lon_d;
    out_alt_q  <= out_alt_d;
    out_lat_q  <= out_lat_d;
    out_lon_q  <= out_lon_d;
    out_nc_q   <= out_nc_d;
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign altitude_o      = out_alt_q;
  assign latitude_o      = out_lat_q;
  assign longitude_o     = out_lon_q;
  assign not_converged_o = out_nc_q;

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in work");

  // the sequencer starts at most one shared unit per cycle
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_go_q, sqrt_go_q, div_go_q, cor_go_q}))
    else $error("two shared units started together");

  // refinement count never passes the cap
  a_iter_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kcnt_q <= KW'(MAX_ITERATIONS))
    else $error("refinement count past cap");

  // a result handed over shows up as valid
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> out_valid_o)
    else $error("result lost on hand-over");

endmodule

`default_nettype wire
